FILE: hw/rtl/mmr_pkg.sv
`default_nettype none
package mmr_pkg;

  localparam int ROUTE_SLOTS_DEF = 16;
  localparam int LFO_COUNT_DEF   = 16;

  localparam logic [3:0] CMD_WRITE  = 4'd0;
  localparam logic [3:0] CMD_AMOUNT = 4'd1;
  localparam logic [3:0] CMD_ENABLE = 4'd2;
  localparam logic [3:0] CMD_REMOVE = 4'd3;
  localparam logic [3:0] CMD_CC     = 4'd4;
  localparam logic [3:0] CMD_VEL    = 4'd5;
  localparam logic [3:0] CMD_AFT    = 4'd6;
  localparam logic [3:0] CMD_WHEEL  = 4'd7;
  localparam logic [3:0] CMD_BEND   = 4'd8;
  localparam logic [3:0] CMD_LFO    = 4'd9;
  localparam logic [3:0] CMD_TICK   = 4'd10;

  localparam logic [2:0] SRC_LFO   = 3'd0;
  localparam logic [2:0] SRC_VEL   = 3'd1;
  localparam logic [2:0] SRC_AFT   = 3'd2;
  localparam logic [2:0] SRC_WHEEL = 3'd3;
  localparam logic [2:0] SRC_BEND  = 3'd4;
  localparam logic [2:0] SRC_CTRL  = 3'd5;
  localparam logic [2:0] SRC_SEQ   = 3'd6;

  localparam logic [2:0] DST_CTRL      = 3'd0;
  localparam logic [2:0] DST_PITCH     = 3'd1;
  localparam logic [2:0] DST_VEL       = 3'd2;
  localparam logic [2:0] DST_GATE      = 3'd3;
  localparam logic [2:0] DST_SEQ_RATE  = 3'd4;
  localparam logic [2:0] DST_LFO_RATE  = 3'd5;
  localparam logic [2:0] DST_LFO_DEPTH = 3'd6;
  localparam logic [2:0] DST_MORPH     = 3'd7;

  localparam logic [1:0] PERF_VEL   = 2'd0;
  localparam logic [1:0] PERF_AFT   = 2'd1;
  localparam logic [1:0] PERF_WHEEL = 2'd2;
  localparam logic [1:0] PERF_BEND  = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE, OP_AMOUNT, OP_ENABLE, OP_REMOVE, OP_CC, OP_PERF, OP_LFO, OP_TICK
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [3:0]         slot;
    logic [2:0]         src;
    logic [6:0]         sidx;
    logic [2:0]         dst;
    logic [7:0]         didx;
    logic signed [15:0] gain;
    logic signed [15:0] off;
    logic               en;
    logic [6:0]         ev_idx;
    logic [1:0]         perf_sel;
    logic signed [15:0] val;
  } req_t;

  typedef logic [14:0] unit_tab_t [128];
  typedef logic signed [15:0] vel_tab_t [128];

  function automatic unit_tab_t mk_unit_tab();
    unit_tab_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 15'((i * 16384 + 63) / 127);
    end
    return t;
  endfunction

  function automatic vel_tab_t mk_vel_tab();
    vel_tab_t t;
    for (int i = 0; i < 128; i++) begin
      t[i] = 16'((i * 32768 + 63) / 127 - 16384);
    end
    return t;
  endfunction

  // v * 16384 / 127 and v * 32768 / 127 - 16384, rounded
  localparam unit_tab_t UNIT_TAB = mk_unit_tab();
  localparam vel_tab_t  VEL_TAB  = mk_vel_tab();

endpackage
`default_nettype wire

FILE: hw/rtl/mmr_ram.sv
`default_nettype none
module mmr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                        wdata,
  input  wire logic                                re,
  input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                             rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: hw/rtl/mmr_front.sv
`default_nettype none
module mmr_front #(
  parameter int ROUTE_SLOTS = mmr_pkg::ROUTE_SLOTS_DEF,
  parameter int LFO_COUNT   = mmr_pkg::LFO_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_command,
  input  wire logic [3:0]         in_route_slot,
  input  wire logic [2:0]         in_route_source,
  input  wire logic [6:0]         in_source_index,
  input  wire logic [2:0]         in_route_dest,
  input  wire logic [7:0]         in_dest_index,
  input  wire logic signed [15:0] in_amount,
  input  wire logic signed [15:0] in_offset,
  input  wire logic               in_enabled,
  input  wire logic [6:0]         in_event_index,
  input  wire logic signed [15:0] in_event_value,
  output logic                    q_valid,
  output mmr_pkg::req_t           q_req,
  input  wire logic               q_pop
);

  mmr_pkg::req_t req;
  logic          keep;
  logic          slot_ok;
  logic [6:0]    v7;
  logic          bneg;
  logic [16:0]   bmag;
  logic [14:0]   b2m;
  logic [14:0]   bq;
  logic signed [15:0] bend_val;
  logic signed [15:0] lfo_val;
  logic signed [15:0] gain_sat;

  mmr_pkg::req_t mem_r [2];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;

  assign v7      = in_event_value[6:0];
  assign slot_ok = ({4'b0, in_route_slot} < 8'(ROUTE_SLOTS));

  // bend: v * 16384 / 8191 = 2v + small correction
  always_comb begin
    bneg = in_event_value[15];
    bmag = bneg ? 17'(-$signed({in_event_value[15], in_event_value}))
                : 17'({1'b0, in_event_value});
    b2m  = 15'({bmag[12:0], 1'b0});
    bq   = b2m;
    if ({2'b0, b2m} + 17'd4095 >= 17'd16382) begin
      bq = b2m + 15'd2;
    end else if ({2'b0, b2m} + 17'd4095 >= 17'd8191) begin
      bq = b2m + 15'd1;
    end
    if (bmag > 17'd8191) begin
      bq = 15'd16384;
    end
    bend_val = bneg ? -$signed({1'b0, bq}) : $signed({1'b0, bq});
  end

  always_comb begin
    lfo_val = in_event_value;
    if (in_event_value > 16'sd16384) begin
      lfo_val = 16'sd16384;
    end else if (in_event_value < -16'sd16384) begin
      lfo_val = -16'sd16384;
    end
    gain_sat = in_amount;
    if (in_amount > 16'sd16384) begin
      gain_sat = 16'sd16384;
    end else if (in_amount < -16'sd16384) begin
      gain_sat = -16'sd16384;
    end
  end

  always_comb begin
    req.op       = mmr_pkg::OP_TICK;
    req.slot     = in_route_slot;
    req.src      = in_route_source;
    req.sidx     = in_source_index;
    req.dst      = in_route_dest;
    req.didx     = in_dest_index;
    req.gain     = gain_sat;
    req.off      = in_offset;
    req.en       = in_enabled;
    req.ev_idx   = in_event_index;
    req.perf_sel = mmr_pkg::PERF_VEL;
    req.val      = in_event_value;
    keep         = 1'b0;
    case (in_command)
      mmr_pkg::CMD_WRITE: begin
        req.op = mmr_pkg::OP_WRITE;
        keep   = slot_ok;
      end
      mmr_pkg::CMD_AMOUNT: begin
        req.op = mmr_pkg::OP_AMOUNT;
        keep   = slot_ok;
      end
      mmr_pkg::CMD_ENABLE: begin
        req.op = mmr_pkg::OP_ENABLE;
        keep   = slot_ok;
      end
      mmr_pkg::CMD_REMOVE: begin
        req.op = mmr_pkg::OP_REMOVE;
        keep   = slot_ok;
      end
      mmr_pkg::CMD_CC: begin
        req.op  = mmr_pkg::OP_CC;
        req.val = $signed({9'b0, v7});
        keep    = 1'b1;
      end
      mmr_pkg::CMD_VEL: begin
        req.op       = mmr_pkg::OP_PERF;
        req.perf_sel = mmr_pkg::PERF_VEL;
        req.val      = mmr_pkg::VEL_TAB[v7];
        keep         = 1'b1;
      end
      mmr_pkg::CMD_AFT: begin
        req.op       = mmr_pkg::OP_PERF;
        req.perf_sel = mmr_pkg::PERF_AFT;
        req.val      = $signed({1'b0, mmr_pkg::UNIT_TAB[v7]});
        keep         = 1'b1;
      end
      mmr_pkg::CMD_WHEEL: begin
        req.op       = mmr_pkg::OP_PERF;
        req.perf_sel = mmr_pkg::PERF_WHEEL;
        req.val      = $signed({1'b0, mmr_pkg::UNIT_TAB[v7]});
        keep         = 1'b1;
      end
      mmr_pkg::CMD_BEND: begin
        req.op       = mmr_pkg::OP_PERF;
        req.perf_sel = mmr_pkg::PERF_BEND;
        req.val      = bend_val;
        keep         = 1'b1;
      end
      mmr_pkg::CMD_LFO: begin
        req.op  = mmr_pkg::OP_LFO;
        req.val = lfo_val;
        keep    = ({1'b0, in_event_index} < 8'(LFO_COUNT));
      end
      mmr_pkg::CMD_TICK: begin
        req.op = mmr_pkg::OP_TICK;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // two-entry request queue, dropped requests are accepted but not queued
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_req    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = 2'(cnt_r + {1'b0, push} - {1'b0, q_pop});
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/mmr_back.sv
`default_nettype none
module mmr_back #(
  parameter int ROUTE_SLOTS = mmr_pkg::ROUTE_SLOTS_DEF,
  parameter int LFO_COUNT   = mmr_pkg::LFO_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  mmr_pkg::req_t      q_req,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [2:0]         out_dest_kind,
  output logic [7:0]         out_dest_number,
  output logic signed [19:0] out_mod_value,
  output logic               out_last
);

  localparam int RT_AW   = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int SC_W    = $clog2(ROUTE_SLOTS + 1);
  localparam int LFO_AW  = (LFO_COUNT > 1) ? $clog2(LFO_COUNT) : 1;
  localparam int SUM_W   = 17 + SC_W;
  localparam int INFO_W  = 37;

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_RD   = 6'b000010,
    B_SRC  = 6'b000100,
    B_MUL  = 6'b001000,
    B_ACC  = 6'b010000,
    B_END  = 6'b100000
  } bstate_t;

  bstate_t state_r, state_nxt;

  logic [ROUTE_SLOTS-1:0] rt_vld_r, rt_vld_nxt, rt_en_r, rt_en_nxt, rt_ctl_r, rt_ctl_nxt;
  logic [127:0]           cv_vld_r, cv_vld_nxt;
  logic [LFO_COUNT-1:0]   lfo_vld_r, lfo_vld_nxt;
  logic signed [15:0]     perf_r [4];
  logic signed [15:0]     perf_nxt [4];

  logic [SC_W-1:0]         cnt_r, cnt_nxt;
  logic                    pass0_r, pass0_nxt;
  logic [6:0]              cur_r, cur_nxt, cand_r, cand_nxt;
  logic                    cand_vld_r, cand_vld_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [32:0]      prod_r, prod_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [2:0]          out_kind_r, out_kind_nxt;
  logic [7:0]          out_num_r, out_num_nxt;
  logic signed [19:0]  out_val_r, out_val_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_free, out_load;

  logic              info_we, info_re, gain_we, gain_re, cv_we, cv_re, lfo_we, lfo_re;
  logic [INFO_W-1:0] info_wdata, info_rdata;
  logic [15:0]       gain_rdata, lfo_rdata;
  logic [6:0]        cv_rdata;

  logic [RT_AW-1:0]   sa, ca;
  logic [LFO_AW-1:0]  la, lsa;
  logic [2:0]         f_src, f_dst;
  logic [6:0]         f_sidx, cidx;
  logic [7:0]         f_didx;
  logic signed [15:0] f_off, gain_s;
  logic [ROUTE_SLOTS-1:0] en_mask, nc_mask;
  logic               any_ctl, later_nc, lfo_ok;

  logic signed [16:0] raw;
  logic               prod_neg;
  logic [32:0]        prod_mag;
  logic [18:0]        q_mag;
  logic signed [19:0] acc;
  logic signed [16:0] mod;

  logic signed [16:0] cl;
  logic signed [22:0] cp;
  logic [22:0]        cpm;
  logic [6:0]         ctrl_v;

  function automatic logic signed [19:0] scale_f(logic [2:0] d, logic signed [16:0] m);
    logic [16:0] x;
    logic [19:0] x15;
    logic signed [19:0] r;
    x   = 17'(m + 17'sd16384);
    x15 = ({3'b0, x} << 4) - {3'b0, x};
    case (d)
      mmr_pkg::DST_PITCH:    r = (20'(m) <<< 4) + (20'(m) <<< 3);
      mmr_pkg::DST_VEL:      r = 20'(m);
      mmr_pkg::DST_GATE:     r = $signed({3'b0, x});
      mmr_pkg::DST_SEQ_RATE: r = $signed(((x15 + 20'd4) >> 3) + 20'd4096);
      mmr_pkg::DST_LFO_RATE: r = $signed(((x15 + 20'd4) >> 3) + 20'd4096);
      default:               r = $signed({3'b0, (x + 17'd1) >> 1});
    endcase
    return r;
  endfunction

  assign sa  = RT_AW'(q_req.slot);
  assign ca  = cnt_r[RT_AW-1:0];
  assign la  = q_req.ev_idx[LFO_AW-1:0];

  assign f_src  = info_rdata[36:34];
  assign f_dst  = info_rdata[33:31];
  assign f_sidx = info_rdata[30:24];
  assign f_didx = info_rdata[23:16];
  assign f_off  = $signed(info_rdata[15:0]);
  assign cidx   = f_didx[6:0];
  assign gain_s = $signed(gain_rdata);
  assign lsa    = f_sidx[LFO_AW-1:0];

  assign info_wdata = {q_req.src, q_req.dst, q_req.sidx, q_req.didx, q_req.off};

  assign en_mask  = rt_vld_r & rt_en_r;
  assign nc_mask  = en_mask & ~rt_ctl_r;
  assign any_ctl  = |(en_mask & rt_ctl_r);
  assign later_nc = |(nc_mask >> (cnt_r + SC_W'(1)));
  assign lfo_ok   = ({1'b0, f_sidx} < 8'(LFO_COUNT)) && lfo_vld_r[lsa];
  assign out_free = !out_vld_r || out_ready;

  always_comb begin
    raw = 17'sd0;
    case (f_src)
      mmr_pkg::SRC_LFO:   raw = lfo_ok ? 17'($signed(lfo_rdata)) : 17'sd0;
      mmr_pkg::SRC_VEL:   raw = 17'(perf_r[0]);
      mmr_pkg::SRC_AFT:   raw = 17'(perf_r[1]);
      mmr_pkg::SRC_WHEEL: raw = 17'(perf_r[2]);
      mmr_pkg::SRC_BEND:  raw = 17'(perf_r[3]);
      mmr_pkg::SRC_CTRL:  raw = cv_vld_r[f_sidx] ?
                                $signed({2'b0, mmr_pkg::UNIT_TAB[cv_rdata]}) : 17'sd0;
      default:            raw = 17'sd0;
    endcase
  end

  // round product / 16384 half away from zero, add offset, saturate
  always_comb begin
    prod_neg = prod_r[32];
    prod_mag = prod_neg ? 33'(-prod_r) : prod_r;
    q_mag    = 19'((prod_mag + 33'd8192) >> 14);
    acc      = (prod_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag})) + 20'(f_off);
    if (acc > 20'sd16384) begin
      mod = 17'sd16384;
    end else if (acc < -20'sd16384) begin
      mod = -17'sd16384;
    end else begin
      mod = 17'(acc);
    end
  end

  // controller value 64 + trunc(sat(sum) * 63 / 16384)
  always_comb begin
    if (sum_r > SUM_W'(16384)) begin
      cl = 17'sd16384;
    end else if (sum_r < -SUM_W'(16384)) begin
      cl = -17'sd16384;
    end else begin
      cl = 17'(sum_r);
    end
    cp  = (23'(cl) <<< 6) - 23'(cl);
    cpm = cp[22] ? 23'(-cp) : 23'(cp);
    ctrl_v = cp[22] ? 7'd64 - 7'(cpm >> 14) : 7'd64 + 7'(cpm >> 14);
  end

  always_comb begin
    state_nxt    = state_r;
    rt_vld_nxt   = rt_vld_r;
    rt_en_nxt    = rt_en_r;
    rt_ctl_nxt   = rt_ctl_r;
    cv_vld_nxt   = cv_vld_r;
    lfo_vld_nxt  = lfo_vld_r;
    perf_nxt     = perf_r;
    cnt_nxt      = cnt_r;
    pass0_nxt    = pass0_r;
    cur_nxt      = cur_r;
    cand_nxt     = cand_r;
    cand_vld_nxt = cand_vld_r;
    sum_nxt      = sum_r;
    prod_nxt     = prod_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_kind_nxt = out_kind_r;
    out_num_nxt  = out_num_r;
    out_val_nxt  = out_val_r;
    out_last_nxt = out_last_r;
    out_load     = 1'b0;
    q_pop        = 1'b0;
    info_we      = 1'b0;
    info_re      = 1'b0;
    gain_we      = 1'b0;
    gain_re      = 1'b0;
    cv_we        = 1'b0;
    cv_re        = 1'b0;
    lfo_we       = 1'b0;
    lfo_re       = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_req.op)
            mmr_pkg::OP_WRITE: begin
              rt_vld_nxt[sa] = 1'b1;
              rt_en_nxt[sa]  = q_req.en;
              rt_ctl_nxt[sa] = (q_req.dst == mmr_pkg::DST_CTRL);
              info_we        = 1'b1;
              gain_we        = 1'b1;
            end
            mmr_pkg::OP_AMOUNT: begin
              gain_we = rt_vld_r[sa];
            end
            mmr_pkg::OP_ENABLE: begin
              if (rt_vld_r[sa]) begin
                rt_en_nxt[sa] = q_req.en;
              end
            end
            mmr_pkg::OP_REMOVE: begin
              rt_vld_nxt[sa] = 1'b0;
              rt_en_nxt[sa]  = 1'b0;
            end
            mmr_pkg::OP_CC: begin
              cv_we                    = 1'b1;
              cv_vld_nxt[q_req.ev_idx] = 1'b1;
            end
            mmr_pkg::OP_PERF: begin
              perf_nxt[q_req.perf_sel] = q_req.val;
            end
            mmr_pkg::OP_LFO: begin
              lfo_we          = 1'b1;
              lfo_vld_nxt[la] = 1'b1;
            end
            mmr_pkg::OP_TICK: begin
              cnt_nxt      = '0;
              pass0_nxt    = 1'b1;
              cand_vld_nxt = 1'b0;
              sum_nxt      = '0;
              state_nxt    = B_RD;
            end
            default: begin
            end
          endcase
        end
      end
      B_RD: begin
        if (cnt_r == SC_W'(ROUTE_SLOTS)) begin
          state_nxt = B_END;
        end else if (en_mask[ca] && (pass0_r || rt_ctl_r[ca])) begin
          info_re   = 1'b1;
          gain_re   = 1'b1;
          state_nxt = B_SRC;
        end else begin
          cnt_nxt = cnt_r + SC_W'(1);
        end
      end
      B_SRC: begin
        if (f_dst == mmr_pkg::DST_CTRL && (pass0_r || cidx > cur_r) &&
            (!cand_vld_r || cidx < cand_r)) begin
          cand_nxt     = cidx;
          cand_vld_nxt = 1'b1;
        end
        if ((f_dst != mmr_pkg::DST_CTRL && pass0_r) ||
            (f_dst == mmr_pkg::DST_CTRL && !pass0_r && cidx == cur_r)) begin
          cv_re     = 1'b1;
          lfo_re    = 1'b1;
          state_nxt = B_MUL;
        end else begin
          cnt_nxt   = cnt_r + SC_W'(1);
          state_nxt = B_RD;
        end
      end
      B_MUL: begin
        prod_nxt  = raw * gain_s;
        state_nxt = B_ACC;
      end
      B_ACC: begin
        if (pass0_r) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_vld_nxt  = 1'b1;
            out_kind_nxt = f_dst;
            out_num_nxt  = f_didx;
            out_val_nxt  = scale_f(f_dst, mod);
            out_last_nxt = !later_nc && !any_ctl;
            cnt_nxt      = cnt_r + SC_W'(1);
            state_nxt    = B_RD;
          end
        end else begin
          sum_nxt   = sum_r + SUM_W'(mod);
          cnt_nxt   = cnt_r + SC_W'(1);
          state_nxt = B_RD;
        end
      end
      B_END: begin
        if (pass0_r) begin
          if (cand_vld_r) begin
            cur_nxt      = cand_r;
            cand_vld_nxt = 1'b0;
            pass0_nxt    = 1'b0;
            cnt_nxt      = '0;
            sum_nxt      = '0;
            state_nxt    = B_RD;
          end else begin
            state_nxt = B_IDLE;
          end
        end else if (out_free) begin
          out_load     = 1'b1;
          out_vld_nxt  = 1'b1;
          out_kind_nxt = mmr_pkg::DST_CTRL;
          out_num_nxt  = {1'b0, cur_r};
          out_val_nxt  = $signed({13'b0, ctrl_v});
          out_last_nxt = !cand_vld_r;
          if (cand_vld_r) begin
            cur_nxt      = cand_r;
            cand_vld_nxt = 1'b0;
            cnt_nxt      = '0;
            sum_nxt      = '0;
            state_nxt    = B_RD;
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  mmr_ram #(.W(INFO_W), .D(ROUTE_SLOTS)) u_info_ram (
    .clk(clk), .we(info_we), .waddr(sa), .wdata(info_wdata),
    .re(info_re), .raddr(ca), .rdata(info_rdata)
  );

  mmr_ram #(.W(16), .D(ROUTE_SLOTS)) u_gain_ram (
    .clk(clk), .we(gain_we), .waddr(sa), .wdata(q_req.gain),
    .re(gain_re), .raddr(ca), .rdata(gain_rdata)
  );

  mmr_ram #(.W(7), .D(128)) u_cv_ram (
    .clk(clk), .we(cv_we), .waddr(q_req.ev_idx), .wdata(q_req.val[6:0]),
    .re(cv_re), .raddr(f_sidx), .rdata(cv_rdata)
  );

  mmr_ram #(.W(16), .D(LFO_COUNT)) u_lfo_ram (
    .clk(clk), .we(lfo_we), .waddr(la), .wdata(q_req.val),
    .re(lfo_re), .raddr(lsa), .rdata(lfo_rdata)
  );

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_kind_r <= out_kind_nxt;
    out_num_r  <= out_num_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_IDLE;
      rt_vld_r   <= '0;
      rt_en_r    <= '0;
      rt_ctl_r   <= '0;
      cv_vld_r   <= '0;
      lfo_vld_r  <= '0;
      perf_r     <= '{default: 16'sd0};
      cnt_r      <= '0;
      pass0_r    <= 1'b0;
      cur_r      <= 7'd0;
      cand_r     <= 7'd0;
      cand_vld_r <= 1'b0;
      sum_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rt_vld_r   <= rt_vld_nxt;
      rt_en_r    <= rt_en_nxt;
      rt_ctl_r   <= rt_ctl_nxt;
      cv_vld_r   <= cv_vld_nxt;
      lfo_vld_r  <= lfo_vld_nxt;
      perf_r     <= perf_nxt;
      cnt_r      <= cnt_nxt;
      pass0_r    <= pass0_nxt;
      cur_r      <= cur_nxt;
      cand_r     <= cand_nxt;
      cand_vld_r <= cand_vld_nxt;
      sum_r      <= sum_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_dest_kind   = out_kind_r;
  assign out_dest_number = out_num_r;
  assign out_mod_value   = out_val_r;
  assign out_last        = out_last_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && state_r == B_IDLE)
    else $error("request popped outside idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result register overwritten");

  a_ctrl_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_END && !pass0_r && cand_vld_r && out_free) |=> cur_r > $past(cur_r))
    else $error("controller order not ascending");

  a_ctrl_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_kind_r == mmr_pkg::DST_CTRL) |->
      (out_val_r > 20'sd0) && (out_val_r < 20'sd128))
    else $error("controller value out of range");

endmodule
`default_nettype wire

FILE: hw/rtl/modulation_matrix_router.sv
`default_nettype none
// channel  direction  handshake            payload
// in_      input      in_valid/in_ready    command, route and feed fields
// out_     output     out_valid/out_ready  dest_kind, dest_number, mod_value, last
//
// route and feed requests pass a two-entry queue and are applied by the back end as it pops them.
// a tick is popped, then takes one pass over the slots for non-controller routes and one
// more pass per distinct controller destination; each pass walks every slot, reads the
// enabled routes it covers and applies those that belong to it.
// rst_n is synchronous; route, controller and lfo entries read as zero until written.
// a full result register stalls the tick walk; a full queue drops in_ready.
module modulation_matrix_router #(
  parameter int ROUTE_SLOTS = mmr_pkg::ROUTE_SLOTS_DEF,
  parameter int LFO_COUNT   = mmr_pkg::LFO_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_command,
  input  wire logic [3:0]         in_route_slot,
  input  wire logic [2:0]         in_route_source,
  input  wire logic [6:0]         in_source_index,
  input  wire logic [2:0]         in_route_dest,
  input  wire logic [7:0]         in_dest_index,
  input  wire logic signed [15:0] in_amount,
  input  wire logic signed [15:0] in_offset,
  input  wire logic               in_enabled,
  input  wire logic [6:0]         in_event_index,
  input  wire logic signed [15:0] in_event_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_dest_kind,
  output logic [7:0]              out_dest_number,
  output logic signed [19:0]      out_mod_value,
  output logic                    out_last
);

  logic          q_valid;
  logic          q_pop;
  mmr_pkg::req_t q_req;

  mmr_front #(.ROUTE_SLOTS(ROUTE_SLOTS), .LFO_COUNT(LFO_COUNT)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_route_slot(in_route_slot),
    .in_route_source(in_route_source), .in_source_index(in_source_index),
    .in_route_dest(in_route_dest), .in_dest_index(in_dest_index),
    .in_amount(in_amount), .in_offset(in_offset), .in_enabled(in_enabled),
    .in_event_index(in_event_index), .in_event_value(in_event_value),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  mmr_back #(.ROUTE_SLOTS(ROUTE_SLOTS), .LFO_COUNT(LFO_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_dest_kind(out_dest_kind), .out_dest_number(out_dest_number),
    .out_mod_value(out_mod_value), .out_last(out_last)
  );

endmodule
`default_nettype wire
